FILE: sv/wps_pkg.sv
// Shared types and constants for the word parallel scrambler.
`timescale 1ns / 1ps
package wps_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned HistW  = 32;
  localparam int unsigned BitsW  = 5;
  localparam int unsigned TapW   = 6;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Effective word width limits
  localparam logic [BitsW-1:0] MinBits = BitsW'(1);
  localparam logic [BitsW-1:0] MaxBits = BitsW'(16);
  localparam logic [ShiftW-1:0] MaxShift = '1;

  // Register reset values
  localparam logic [BitsW-1:0] BitsRst = BitsW'(1);
  localparam logic [TapW-1:0]  Tap1Rst = TapW'(18);
  localparam logic [TapW-1:0]  Tap2Rst = TapW'(23);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMode  = CfgIdxW'(0),
    CfgBits  = CfgIdxW'(1),
    CfgTap1  = CfgIdxW'(2),
    CfgTap2  = CfgIdxW'(3)
  } cfg_idx_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic             descramble;
    logic [BitsW-1:0] word_bits;
    logic [TapW-1:0]  first_tap;
    logic [TapW-1:0]  second_tap;
  } cfg_t;

endpackage

FILE: sv/wps_core.sv
// Scrambler datapath: tap XOR, word mask and history update for one word.
`timescale 1ns / 1ps
module wps_core (
  input  wps_pkg::cfg_t                    cfg_i,
  input  logic [wps_pkg::HistW-1:0]        hist_i,
  input  logic [wps_pkg::WordW-1:0]        word_i,
  output logic [wps_pkg::WordW-1:0]        result_o,
  output logic [wps_pkg::HistW-1:0]        hist_next_o
);

  logic [wps_pkg::BitsW-1:0]  nb;
  logic [wps_pkg::WordW-1:0]  mask;
  logic [wps_pkg::ShiftW-1:0] s1;
  logic [wps_pkg::ShiftW-1:0] s2;
  logic [wps_pkg::HistW-1:0]  tap_sum;
  logic [wps_pkg::WordW-1:0]  feed;

  function automatic logic [wps_pkg::ShiftW-1:0] tap_shift(
    input logic [wps_pkg::TapW-1:0]  tap,
    input logic [wps_pkg::BitsW-1:0] bits
  );
    logic [wps_pkg::TapW-1:0] nb_ext;
    logic [wps_pkg::TapW-1:0] diff;
    nb_ext = wps_pkg::TapW'(bits);
    diff   = tap - nb_ext;
    if (tap <= nb_ext) begin
      return '0;
    end else if (diff > wps_pkg::TapW'(wps_pkg::MaxShift)) begin
      return wps_pkg::MaxShift;
    end else begin
      return diff[wps_pkg::ShiftW-1:0];
    end
  endfunction

  // Clamp the word width into 1..16
  always_comb begin
    if (cfg_i.word_bits < wps_pkg::MinBits) begin
      nb = wps_pkg::MinBits;
    end else if (cfg_i.word_bits > wps_pkg::MaxBits) begin
      nb = wps_pkg::MaxBits;
    end else begin
      nb = cfg_i.word_bits;
    end
  end

  assign mask = wps_pkg::WordW'(((wps_pkg::WordW+1)'(1) << nb) - (wps_pkg::WordW+1)'(1));
  assign s1   = tap_shift(cfg_i.first_tap, nb);
  assign s2   = tap_shift(cfg_i.second_tap, nb);

  // Combine both taps with the incoming word
  assign tap_sum  = (hist_i >> s1) ^ (hist_i >> s2);
  assign result_o = (tap_sum[wps_pkg::WordW-1:0] ^ word_i) & mask;

  // Feed back the output when scrambling, the raw input when descrambling
  assign feed = cfg_i.descramble ? word_i : result_o;

  assign hist_next_o = ((hist_i << nb) & ~{{(wps_pkg::HistW-wps_pkg::WordW){1'b0}}, mask})
                     | {{(wps_pkg::HistW-wps_pkg::WordW){1'b0}}, feed};

endmodule

FILE: sv/word_parallel_scrambler.sv
// Top level of the word parallel multiplicative scrambler / descrambler.
//
//  channel | handshake                     | payload
//  --------+-------------------------------+------------------------------------
//  input   | in_valid_i / in_ready_o       | data_word_i[15:0], block_end_i
//  output  | out_valid_o / out_ready_i     | result_word_o[15:0], block_end_out_o
//  config  | cfg_valid_i / cfg_ready_o     | cfg_index_i[7:0], cfg_data_i[7:0]
//
// One word per cycle sustained while the output is not stalled; a word passes the input
// register, then the tap XOR and history update into the result register.
// The history register loop is the recurrence that sets the rate.
// Reset clears history and loads the register defaults; config is always ready.
// A stalled output holds its register; the input register still takes a new word
// in the cycle the pending result leaves.
`timescale 1ns / 1ps
module word_parallel_scrambler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [wps_pkg::WordW-1:0]       data_word_i,
  input  logic                            block_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wps_pkg::WordW-1:0]       result_word_o,
  output logic                            block_end_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wps_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [wps_pkg::CfgDataW-1:0]    cfg_data_i
);

  wps_pkg::cfg_t                  cfg_q, cfg_d;
  logic                           cfg_hit;
  logic                           cfg_we;
  logic [wps_pkg::HistW-1:0]      hist_q, hist_d, hist_next;
  logic                           in_vld_q;
  logic [wps_pkg::WordW-1:0]      in_word_q;
  logic                           in_end_q;
  logic                           out_vld_q;
  logic [wps_pkg::WordW-1:0]      out_word_q;
  logic                           out_end_q;
  logic [wps_pkg::WordW-1:0]      result;
  logic                           fire;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b1;
    unique case (wps_pkg::cfg_idx_e'(cfg_index_i))
      wps_pkg::CfgMode: cfg_d.descramble = cfg_data_i[0];
      wps_pkg::CfgBits: cfg_d.word_bits  = cfg_data_i[wps_pkg::BitsW-1:0];
      wps_pkg::CfgTap1: cfg_d.first_tap  = cfg_data_i[wps_pkg::TapW-1:0];
      wps_pkg::CfgTap2: cfg_d.second_tap = cfg_data_i[wps_pkg::TapW-1:0];
      default: cfg_hit = 1'b0;
    endcase
  end

  assign cfg_we = cfg_valid_i && cfg_ready_o && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.descramble <= 1'b0;
      cfg_q.word_bits  <= wps_pkg::BitsRst;
      cfg_q.first_tap  <= wps_pkg::Tap1Rst;
      cfg_q.second_tap <= wps_pkg::Tap2Rst;
    end else if (cfg_we) begin
      cfg_q <= cfg_d;
    end
  end

  // Advance the compute stage when the result register is free or its word is being taken
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  // Hold the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= data_word_i;
      in_end_q  <= block_end_i;
    end
  end

  wps_core u_core (
    .cfg_i       (cfg_q),
    .hist_i      (hist_q),
    .word_i      (in_word_q),
    .result_o    (result),
    .hist_next_o (hist_next)
  );

  // Clear history on any register write, else advance it per word
  always_comb begin
    hist_d = hist_q;
    if (cfg_we) begin
      hist_d = '0;
    end else if (fire) begin
      hist_d = hist_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= result;
      out_end_q  <= in_end_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign result_word_o   = out_word_q;
  assign block_end_out_o = out_end_q;

  // A register write leaves history cleared
  a_cfg_clears_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (hist_q == '0))
    else $error("history not cleared after configuration write");

  // A word leaving the input register always lands in the result register
  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("result register empty after compute");

  // A held word with a free result register moves on
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_vld_q) |-> fire)
    else $error("compute stage stalled with free result register");

  // Scrambling feeds the output back: newest history bit equals result bit 0
  a_scramble_feedback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !cfg_q.descramble && !cfg_we) |=> (hist_q[0] == out_word_q[0]))
    else $error("scrambler feedback mismatch");

endmodule
